FILE: sv/sdf_pkg.sv
// sdf_pkg: shared types and constants for the set difference filter
// no dependencies; imported by sdf_cam and set_difference_filter
`default_nettype none

package sdf_pkg;

    // field widths fixed by the stream format
    localparam int VALUE_W     = 64;
    localparam int POS_FIELD_W = 16;
    localparam int OUT_DATA_W  = VALUE_W + POS_FIELD_W;

    // mode codes carried in s_tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TEST   = 1'b1;

    // commands from the datapath to the exclusion store
    typedef struct packed {
        logic insert_en;
        logic clear_en;
    } sdf_cam_ctrl_t;

    // lookup status from the exclusion store
    typedef struct packed {
        logic hit;
        logic full;
    } sdf_cam_stat_t;

endpackage

`default_nettype wire

FILE: sv/sdf_cam.sv
// sdf_cam: content-addressed exclusion store with parallel match
// depends on sdf_pkg for the value width and control/status structs
`default_nettype none

module sdf_cam
    import sdf_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdf_cam_ctrl_t      ctrl,
    input  wire logic [VALUE_W-1:0] key,
    output sdf_cam_stat_t           stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0] values_reg [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [DEPTH-1:0]   match;
    logic [IDX_W-1:0]   wr_idx;

    assign wr_idx = count_reg[IDX_W-1:0];

    // compare the key against every entry at once
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = valid_reg[i] && (values_reg[i] == key);
        end
    end

    assign stat.hit  = |match;
    assign stat.full = (count_reg == CNT_W'(DEPTH));

    // fill from the bottom, clear everything at end of list
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (ctrl.clear_en)
        begin
            valid_next = '0;
            count_next = '0;
        end
        else if (ctrl.insert_en)
        begin
            valid_next[wr_idx] = 1'b1;
            count_next         = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // entry payload, read only while valid
    always_ff @(posedge clk)
    begin
        if (ctrl.insert_en && !ctrl.clear_en)
        begin
            values_reg[wr_idx] <= key;
        end
    end

endmodule

`default_nettype wire

FILE: sv/set_difference_filter.sv
// set_difference_filter: top level, input register, position counter, result register
// depends on sdf_pkg and sdf_cam
//
// Streams the set difference of two integer lists. A word with s_tuser = 0 inserts
// s_tdata into an exclusion set of SET_DEPTH entries (duplicates ignored; a new value
// arriving while the set is full is dropped and raises a sticky overflow flag). A word
// with s_tuser = 1 tests s_tdata and yields one result word: kept = 1 when the value is
// not in the set, the value itself, its zero-based position in the list (saturating at
// 2^POSITION_BITS-1, low 16 bits shown) and the overflow flag. A test word with s_tlast
// set ends the list: the set and the position counter clear after its result. The block
// takes one word per cycle and registers a test's result from the input register; the
// rate is set by the parallel compare of the input register against all set entries,
// and it holds while m_tready keeps up.
`default_nettype none

module set_difference_filter
    import sdf_pkg::*;
#(
    parameter int SET_DEPTH     = 64,
    parameter int POSITION_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [VALUE_W-1:0]    s_tdata,   // [63:0] value
    input  wire logic                  s_tuser,   // [0] mode
    input  wire logic                  s_tlast,   // end_of_list
    // result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [63:0] out_value, [79:64] position
    output logic [1:0]                 m_tuser,   // [0] kept, [1] set_overflowed
    output logic                       m_tlast    // list_done
);

    logic                     in_valid_reg;
    logic [VALUE_W-1:0]       in_value_reg;
    logic                     in_mode_reg;
    logic                     in_last_reg;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     ovf_reg;
    logic                     ovf_next;

    logic                     out_valid_reg;
    logic [VALUE_W-1:0]       out_value_reg;
    logic [POS_FIELD_W-1:0]   out_pos_reg;
    logic                     out_kept_reg;
    logic                     out_ovf_reg;
    logic                     out_last_reg;

    logic                     out_free;
    logic                     advance;
    logic                     is_test;
    logic                     is_insert;
    logic [31:0]              pos_wide;
    sdf_cam_ctrl_t            cam_ctrl;
    sdf_cam_stat_t            cam_stat;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // exclusion store
    sdf_cam #(
        .DEPTH (SET_DEPTH)
    ) u_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cam_ctrl),
        .key   (in_value_reg),
        .stat  (cam_stat)
    );

    // a held word moves on unless it is a test blocked by a full result register
    assign is_test   = in_valid_reg && (in_mode_reg == MODE_TEST);
    assign is_insert = in_valid_reg && (in_mode_reg == MODE_INSERT);
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!is_test || out_free);
    assign s_tready  = !in_valid_reg || advance;

    assign cam_ctrl.insert_en = advance && is_insert && !cam_stat.hit && !cam_stat.full;
    assign cam_ctrl.clear_en  = advance && is_test && in_last_reg;

    // position counter and sticky overflow
    always_comb
    begin
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        if (advance && is_insert && !cam_stat.hit && cam_stat.full)
        begin
            ovf_next = 1'b1;
        end
        if (advance && is_test)
        begin
            if (in_last_reg)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
        end
    end

    assign pos_wide = 32'(pos_reg);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_value_reg <= s_tdata;
            in_mode_reg  <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // control state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
            if (advance && is_test)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && is_test)
        begin
            out_value_reg <= in_value_reg;
            out_pos_reg   <= pos_wide[POS_FIELD_W-1:0];
            out_kept_reg  <= !cam_stat.hit;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_value_reg};
    assign m_tuser  = {out_ovf_reg, out_kept_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: tb/sv/set_difference_checker.sv
// set_difference_checker: watches both streams of the set difference filter,
// predicts every result word and compares it field by field
// depends on sdf_pkg
module set_difference_checker
    import sdf_pkg::*;
#(
    parameter int SET_DEPTH     = 64,
    parameter int POSITION_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [VALUE_W-1:0]    s_tdata,   // [63:0] value
    input  wire logic                  s_tuser,   // [0] mode
    input  wire logic                  s_tlast,   // end_of_list
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,   // [63:0] out_value, [79:64] position
    input  wire logic [1:0]            m_tuser,   // [0] kept, [1] set_overflowed
    input  wire logic                  m_tlast,   // list_done
    output int                         mismatches,
    output int                         awaited
);

    localparam longint unsigned POS_TOP = (64'd1 << POSITION_BITS) - 64'd1;

    typedef struct packed {
        logic                   kept;
        logic [VALUE_W-1:0]     value;
        logic [POS_FIELD_W-1:0] position;
        logic                   done;
        logic                   overflowed;
    } filter_result_t;

    // shadow of the exclusion store and list state
    logic [VALUE_W-1:0] excl_values [SET_DEPTH];
    bit                 excl_valid [SET_DEPTH];
    int                 excl_count;
    longint unsigned    list_pos;
    bit                 store_overflow;
    int                 fail_count;
    filter_result_t     awaited_results [$];

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_list();
        for (int i = 0; i < SET_DEPTH; i++)
            excl_valid[i] = 1'b0;
        excl_count = 0;
        list_pos   = 0;
    endtask

    // apply one accepted input word to the shadow state, queue its result if any
    task automatic absorb_word(input logic mode, input logic [VALUE_W-1:0] v,
                               input logic last);
        bit             hit;
        filter_result_t res;
        hit = 1'b0;
        for (int i = 0; i < SET_DEPTH; i++)
            if (excl_valid[i] && excl_values[i] == v)
                hit = 1'b1;
        if (mode == MODE_INSERT)
        begin
            // duplicates change nothing, a new value on a full store is dropped
            if (!hit)
            begin
                if (excl_count < SET_DEPTH)
                begin
                    excl_values[excl_count] = v;
                    excl_valid[excl_count]  = 1'b1;
                    excl_count++;
                end
                else
                    store_overflow = 1'b1;
            end
        end
        else
        begin
            res.kept       = !hit;
            res.value      = v;
            res.position   = list_pos[POS_FIELD_W-1:0];
            res.done       = last;
            res.overflowed = store_overflow;
            awaited_results = {awaited_results, res};
            // position saturates, overflow stays across lists
            if (list_pos < POS_TOP)
                list_pos++;
            if (last)
                clear_list();
        end
    endtask

    task automatic check_result_word();
        filter_result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected result word", m_tdata[VALUE_W-1:0], '0);
            return;
        end
        want = awaited_results.pop_front();
        if (m_tuser[0] !== want.kept)
            report_mismatch("kept", m_tuser[0], want.kept);
        if (m_tdata[VALUE_W-1:0] !== want.value)
            report_mismatch("out_value", m_tdata[VALUE_W-1:0], want.value);
        if (m_tdata[OUT_DATA_W-1:VALUE_W] !== want.position)
            report_mismatch("position", m_tdata[OUT_DATA_W-1:VALUE_W], want.position);
        if (m_tlast !== want.done)
            report_mismatch("list_done", m_tlast, want.done);
        if (m_tuser[1] !== want.overflowed)
            report_mismatch("set_overflowed", m_tuser[1], want.overflowed);
    endtask

    // watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_list();
            store_overflow = 1'b0;
            fail_count     = 0;
            awaited_results.delete();
            mismatches <= 0;
            awaited    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_word(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result_word();
            mismatches <= fail_count;
            awaited    <= awaited_results.size();
        end
    end

endmodule

FILE: tb/sv/set_difference_filter_test.sv
// set_difference_filter_test: stimulus, clock, reset and verdict for the filter
// depends on sdf_pkg, set_difference_filter and set_difference_checker
module set_difference_filter_test;
    import sdf_pkg::*;

    localparam int SET_DEPTH     = 64;
    localparam int POSITION_BITS = 16;

    localparam logic [VALUE_W-1:0] ZERO_VAL = 64'h0000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] ONES_VAL = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MIN_VAL  = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] MAX_VAL  = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata  = '0;   // [63:0] value
    logic                  s_tuser  = 1'b0; // [0] mode
    logic                  s_tlast  = 1'b0; // end_of_list
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [63:0] out_value, [79:64] position
    logic [1:0]            m_tuser;         // [0] kept, [1] set_overflowed
    logic                  m_tlast;         // list_done

    int                 mismatches;
    int                 awaited;
    int                 words_sent = 0;
    bit                 calm       = 1'b0;
    logic [VALUE_W-1:0] value_pool [16];

    set_difference_filter #(
        .SET_DEPTH     (SET_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    set_difference_checker #(
        .SET_DEPTH     (SET_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always #5 clk = ~clk;

    // random back-pressure on the result side
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 13);
    end

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic mode, input logic [VALUE_W-1:0] v, input logic last);
        while (!calm && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= mode;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // hold off the sender until every result word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(3) == 0)
            return {$urandom, $urandom};
        return value_pool[$urandom_range(15)];
    endfunction

    // one list: mostly inserts followed by tests, sometimes a scrambled one
    task automatic random_list();
        logic [VALUE_W-1:0] members [$];
        logic [VALUE_W-1:0] v;
        logic               mode;
        int                 n_ins;
        int                 n_tests;
        n_ins   = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        n_tests = $urandom_range(1, 10);
        if ($urandom_range(5) == 0)
        begin
            // interleaved modes, stray end marks, maybe no end at all
            repeat (n_ins + n_tests)
            begin
                mode = $urandom_range(1) ? MODE_TEST : MODE_INSERT;
                if (members.size() != 0 && $urandom_range(1))
                    v = members[$urandom_range(members.size() - 1)];
                else
                    v = pick_value();
                if (mode == MODE_INSERT)
                    members = {members, v};
                send_word(mode, v, $urandom_range(7) == 0);
            end
        end
        else
        begin
            repeat (n_ins)
            begin
                if (members.size() != 0 && $urandom_range(4) == 0)
                    v = members[$urandom_range(members.size() - 1)];
                else
                    v = pick_value();
                members = {members, v};
                send_word(MODE_INSERT, v, 1'b0);
            end
            for (int k = 0; k < n_tests; k++)
            begin
                if (members.size() != 0 && $urandom_range(1))
                    v = members[$urandom_range(members.size() - 1)];
                else
                    v = pick_value();
                send_word(MODE_TEST, v, k == n_tests - 1);
            end
        end
    endtask

    task automatic random_lists(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
            random_list();
    endtask

    // fill the store, repeat a member on the full store, then overflow it
    task automatic fill_store();
        logic [VALUE_W-1:0] members [$];
        logic [VALUE_W-1:0] fresh;
        logic [VALUE_W-1:0] dropped;
        send_word(MODE_TEST, pick_value(), 1'b1);
        repeat (SET_DEPTH)
        begin
            fresh   = {$urandom, $urandom};
            members = {members, fresh};
            send_word(MODE_INSERT, fresh, 1'b0);
        end
        send_word(MODE_INSERT, members[10], 1'b0);
        send_word(MODE_TEST, members[10], 1'b0);
        dropped = {$urandom, $urandom};
        send_word(MODE_INSERT, dropped, 1'b0);
        send_word(MODE_TEST, members[0], 1'b0);
        send_word(MODE_TEST, members[SET_DEPTH - 1], 1'b0);
        send_word(MODE_TEST, dropped, 1'b1);
    endtask

    // run limit
    initial
    begin
        #4_000_000;
        $display("set_difference_filter regression: fail");
        $finish;
    end

    initial
    begin
        value_pool[0] = ZERO_VAL;
        value_pool[1] = ONES_VAL;
        value_pool[2] = MIN_VAL;
        value_pool[3] = MAX_VAL;
        value_pool[4] = 64'h0000_0000_0000_0001;
        value_pool[5] = 64'hFFFF_FFFF_FFFF_FFFE;
        for (int i = 6; i < 16; i++)
            value_pool[i] = {$urandom, $urandom};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // test on an empty set
        send_word(MODE_TEST, ZERO_VAL, 1'b0);
        // extremes, a duplicate, and an end mark on an insert
        send_word(MODE_INSERT, ZERO_VAL, 1'b0);
        send_word(MODE_INSERT, ONES_VAL, 1'b0);
        send_word(MODE_INSERT, MIN_VAL, 1'b0);
        send_word(MODE_INSERT, MAX_VAL, 1'b0);
        send_word(MODE_INSERT, ZERO_VAL, 1'b0);
        send_word(MODE_INSERT, 64'h0000_0000_0000_0005, 1'b1);
        send_word(MODE_TEST, ZERO_VAL, 1'b0);
        send_word(MODE_TEST, ONES_VAL, 1'b0);
        send_word(MODE_TEST, MIN_VAL, 1'b0);
        send_word(MODE_TEST, MAX_VAL, 1'b0);
        send_word(MODE_TEST, 64'h0000_0000_0000_0005, 1'b0);
        send_word(MODE_TEST, 64'h0000_0000_0000_0001, 1'b0);
        send_word(MODE_TEST, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        send_word(MODE_TEST, MIN_VAL, 1'b1);
        // set and position are clear again
        send_word(MODE_TEST, MIN_VAL, 1'b0);
        send_word(MODE_INSERT, 64'h0000_0000_0000_0001, 1'b0);
        send_word(MODE_TEST, 64'h0000_0000_0000_0001, 1'b1);
        drain();

        random_lists(220);
        drain();
        fill_store();
        // long stretch with no idling on either side
        calm = 1'b1;
        random_lists(120);
        calm = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("set_difference_filter regression: pass");
        else
            $display("set_difference_filter regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/sdf_pkg.sv
sv/sdf_cam.sv
sv/set_difference_filter.sv
tb/sv/set_difference_checker.sv
tb/sv/set_difference_filter_test.sv
